@@ rtl/core/ctod_pkg.sv @@
// ----------------------------------------------------------------------------
// ctod_pkg
// Shared types and constants for the calendar time-of-day counter.
// ----------------------------------------------------------------------------
package ctod_pkg;

  localparam logic [32:0] ONE_BILLION = 33'd1_000_000_000;

  localparam logic [6:0]  SEC_MAX     = 7'd59;
  localparam logic [6:0]  MIN_MAX     = 7'd59;
  localparam logic [5:0]  HOUR_MAX    = 6'd23;
  localparam logic [5:0]  DAY_SAFE    = 6'd28;
  localparam logic [4:0]  MONTH_MAX   = 5'd12;

  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [15:0] RESET_YEAR  = 16'd1970;

  localparam logic [3:0]  MON_FEB = 4'd2;
  localparam logic [3:0]  MON_APR = 4'd4;
  localparam logic [3:0]  MON_JUN = 4'd6;
  localparam logic [3:0]  MON_SEP = 4'd9;
  localparam logic [3:0]  MON_NOV = 4'd11;

  localparam logic [5:0]  LEN_FEB      = 6'd28;
  localparam logic [5:0]  LEN_FEB_LEAP = 6'd29;
  localparam logic [5:0]  LEN_SHORT    = 6'd30;
  localparam logic [5:0]  LEN_LONG     = 6'd31;

  // y / 25 as (y * ceil(2^21 / 25)) >> 21, exact for any 16-bit year
  localparam logic [16:0] DIV25_MUL   = 17'd83887;
  localparam int          DIV25_SHIFT = 21;

  typedef struct packed {
    logic tick;     // add delta to runtime and accumulator
    logic load;     // load calendar, clear accumulator
    logic step;     // take one second off the accumulator
    logic capture;  // copy state into the output register
  } ctod_cmd_t;

  typedef struct packed {
    logic acc_over; // accumulator strictly above one billion
  } ctod_sts_t;

  function automatic logic [5:0] month_len(input logic [3:0] month, input logic leap);
    logic [5:0] len;
    case (month)
      MON_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/calendar_time_of_day_counter.sv @@
// ----------------------------------------------------------------------------
// calendar_time_of_day_counter
// Runtime counter and Gregorian calendar clock driven by nanosecond ticks.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): func = 0 is a tick beat that adds
//   delta_ns to the 64-bit runtime and to the sub-second accumulator;
//   func = 1 is a set beat that loads the calendar and clears the
//   accumulator, leaving the runtime alone.
//   Output channel (out_valid / out_stall): one beat per input beat, giving
//   the calendar and the runtime after that input beat.
// Timing
//   The beat is taken, then the accumulator gives up one second per cycle
//   while it is above one billion (0 to 5 seconds per tick), then, once the
//   output register is free, it is loaded with the result. A new beat is
//   taken only after that, in the cycle after the load.
// Reset
//   Synchronous, active high: runtime and accumulator clear, calendar goes
//   to 00:00:00 on 1 January 1970, output is empty.
// Stall
//   A waiting result holds steady; the next beat is accepted and processed
//   meanwhile, and only its output hand-off waits for the register to free.
// ----------------------------------------------------------------------------
module calendar_time_of_day_counter import ctod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] delta_ns,
  input  logic [5:0]  load_seconds,
  input  logic [5:0]  load_minutes,
  input  logic [4:0]  load_hours,
  input  logic [4:0]  load_day,
  input  logic [3:0]  load_month,
  input  logic [15:0] load_year,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  cur_seconds,
  output logic [5:0]  cur_minutes,
  output logic [4:0]  cur_hours,
  output logic [4:0]  cur_day,
  output logic [3:0]  cur_month,
  output logic [15:0] cur_year,
  output logic [63:0] runtime_ns
);

  ctod_cmd_t cmd;
  ctod_sts_t sts;

  // sequencing: accept, second steps, output hand-off
  ctod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // counters, calendar carry chain and output register
  ctod_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .delta_ns     (delta_ns),
    .load_seconds (load_seconds),
    .load_minutes (load_minutes),
    .load_hours   (load_hours),
    .load_day     (load_day),
    .load_month   (load_month),
    .load_year    (load_year),
    .cur_seconds  (cur_seconds),
    .cur_minutes  (cur_minutes),
    .cur_hours    (cur_hours),
    .cur_day      (cur_day),
    .cur_month    (cur_month),
    .cur_year     (cur_year),
    .runtime_ns   (runtime_ns)
  );

endmodule

@@ rtl/core/ctod_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctod_ctrl
// Controller: takes an input beat, steps seconds, hands the result on.
// ----------------------------------------------------------------------------
module ctod_ctrl import ctod_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      func,
  output logic      out_valid,
  input  logic      out_stall,
  output ctod_cmd_t cmd,
  input  ctod_sts_t sts
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    case (state)
      S_IDLE: begin
        cmd.tick = accept && !func;
        cmd.load = accept && func;
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.acc_over) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/ctod_dp.sv @@
// ----------------------------------------------------------------------------
// ctod_dp
// Datapath: runtime, sub-second accumulator, calendar and output register.
// ----------------------------------------------------------------------------
module ctod_dp import ctod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctod_cmd_t   cmd,
  output ctod_sts_t   sts,
  input  logic [31:0] delta_ns,
  input  logic [5:0]  load_seconds,
  input  logic [5:0]  load_minutes,
  input  logic [4:0]  load_hours,
  input  logic [4:0]  load_day,
  input  logic [3:0]  load_month,
  input  logic [15:0] load_year,
  output logic [5:0]  cur_seconds,
  output logic [5:0]  cur_minutes,
  output logic [4:0]  cur_hours,
  output logic [4:0]  cur_day,
  output logic [3:0]  cur_month,
  output logic [15:0] cur_year,
  output logic [63:0] runtime_ns
);

  logic [63:0] total_runtime;
  logic [32:0] subsecond_acc;
  logic [5:0]  seconds_reg;
  logic [5:0]  minutes_reg;
  logic [4:0]  hours_reg;
  logic [4:0]  day_reg;
  logic [3:0]  month_reg;
  logic [15:0] year_reg;
  logic        leap;

  logic [5:0]  seconds_next;
  logic [5:0]  minutes_next;
  logic [4:0]  hours_next;
  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [15:0] year_next;
  logic        leap_next;

  logic [32:0] div25_prod;
  logic [11:0] div25_q;
  logic [15:0] div25_back;

  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [5:0]  len_plus1;
  logic [5:0]  day_mod;
  logic [4:0]  month_inc;

  assign sts.acc_over = (subsecond_acc > ONE_BILLION);

  // Leap flag of year_reg, registered. It catches up with a year change in the next cycle;
  // the step that changes the year leaves day 1, so no rollover reads it stale.
  assign div25_prod = {17'd0, year_reg} * {16'd0, DIV25_MUL};
  assign div25_q    = div25_prod[DIV25_SHIFT +: 12];
  assign div25_back = {div25_q, 4'd0} + {1'b0, div25_q, 3'd0} + {4'd0, div25_q};
  assign leap_next  = (year_reg[1:0] == 2'd0) &&
                      ((div25_back != year_reg) || (year_reg[3:0] == 4'd0));

  assign sec_inc   = {1'b0, seconds_reg} + 7'd1;
  assign min_inc   = {1'b0, minutes_reg} + 7'd1;
  assign hour_inc  = {1'b0, hours_reg} + 6'd1;
  assign day_inc   = {1'b0, day_reg} + 6'd1;
  assign month_inc = {1'b0, month_reg} + 5'd1;
  assign len_plus1 = month_len(month_reg, leap) + 6'd1;
  // day_inc is below twice any month length, so one subtract is the modulo
  assign day_mod   = (day_inc >= len_plus1) ? (day_inc - len_plus1) : day_inc;

  // one-second advance with carries
  always_comb begin
    seconds_next = seconds_reg;
    minutes_next = minutes_reg;
    hours_next   = hours_reg;
    day_next     = day_reg;
    month_next   = month_reg;
    year_next    = year_reg;
    if (sec_inc <= SEC_MAX) begin
      seconds_next = sec_inc[5:0];
    end else begin
      seconds_next = '0;
      if (min_inc <= MIN_MAX) begin
        minutes_next = min_inc[5:0];
      end else begin
        minutes_next = '0;
        if (hour_inc <= HOUR_MAX) begin
          hours_next = hour_inc[4:0];
        end else begin
          hours_next = '0;
          if (day_inc <= DAY_SAFE) begin
            day_next = day_inc[4:0];
          end else if (day_mod != 6'd0) begin
            day_next = day_mod[4:0];
          end else begin
            day_next = RESET_DAY;
            if (month_inc <= MONTH_MAX) begin
              month_next = month_inc[3:0];
            end else begin
              month_next = RESET_MONTH;
              year_next  = year_reg + 16'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_runtime <= '0;
      subsecond_acc <= '0;
      seconds_reg   <= '0;
      minutes_reg   <= '0;
      hours_reg     <= '0;
      day_reg       <= RESET_DAY;
      month_reg     <= RESET_MONTH;
      year_reg      <= RESET_YEAR;
      leap          <= 1'b0;
    end else begin
      leap <= leap_next;
      if (cmd.load) begin
        seconds_reg   <= load_seconds;
        minutes_reg   <= load_minutes;
        hours_reg     <= load_hours;
        day_reg       <= load_day;
        month_reg     <= load_month;
        year_reg      <= load_year;
        subsecond_acc <= '0;
      end else if (cmd.tick) begin
        total_runtime <= total_runtime + {32'd0, delta_ns};
        subsecond_acc <= subsecond_acc + {1'b0, delta_ns};
      end else if (cmd.step) begin
        subsecond_acc <= subsecond_acc - ONE_BILLION;
        seconds_reg   <= seconds_next;
        minutes_reg   <= minutes_next;
        hours_reg     <= hours_next;
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_seconds <= seconds_reg;
      cur_minutes <= minutes_reg;
      cur_hours   <= hours_reg;
      cur_day     <= day_reg;
      cur_month   <= month_reg;
      cur_year    <= year_reg;
      runtime_ns  <= total_runtime;
    end
  end

endmodule

@@ rtl/core/ctod_chk.sv @@
// ----------------------------------------------------------------------------
// ctod_chk
// Port-level checks for the calendar time-of-day counter, bound to the top.
// ----------------------------------------------------------------------------
module ctod_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] cur_year,
  input logic [63:0] runtime_ns
);

  // stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(cur_year) && $stable(runtime_ns))
    else $error("output payload changed under stall");

  // an accepted beat keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open straight after a beat");

  // a new result only comes out of a busy cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a beat in progress");

endmodule

bind calendar_time_of_day_counter ctod_chk u_ctod_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cur_year   (cur_year),
  .runtime_ns (runtime_ns)
);
